@@ sv/nearest_track_delta_r_matcher_top_defines.svh @@
// Assertion macros for the checker file of the matcher.
`ifndef NEAREST_TRACK_DELTA_R_MATCHER_TOP_DEFINES_SVH
`define NEAREST_TRACK_DELTA_R_MATCHER_TOP_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define NTDRM_ASSERT_IMP(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define NTDRM_ASSERT_NXT(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ sv/ntdrm_pkg.sv @@
package ntdrm_pkg;

    // Request opcodes.
    localparam logic [1:0] OP_CLEAR  = 2'd0;
    localparam logic [1:0] OP_APPEND = 2'd1;
    localparam logic [1:0] OP_QUERY  = 2'd2;

    // Cut selections; the two unused codes behave as a plain pass.
    localparam logic [2:0] CUT_PASS   = 3'd0;
    localparam logic [2:0] CUT_WINDOW = 3'd1;
    localparam logic [2:0] CUT_DR     = 3'd2;
    localparam logic [2:0] CUT_ETA    = 3'd3;
    localparam logic [2:0] CUT_PHI    = 3'd4;
    localparam logic [2:0] CUT_DZ     = 3'd5;

    // Register indexes (byte address divided by four).
    localparam logic [2:0] REG_CUT_MODE = 3'd0;
    localparam logic [2:0] REG_DR_CUT   = 3'd1;
    localparam logic [2:0] REG_ETA_CUT  = 3'd2;
    localparam logic [2:0] REG_PHI_CUT  = 3'd3;
    localparam logic [2:0] REG_DZ_CUT   = 3'd4;

    localparam int APB_AW = 5;
    localparam int APB_DW = 32;

    // Register reset values.
    localparam logic [2:0]  RST_CUT_MODE = CUT_DR;
    localparam logic [15:0] RST_DR_CUT   = 16'd1638;
    localparam logic [15:0] RST_ETA_CUT  = 16'd2048;
    localparam logic [15:0] RST_PHI_CUT  = 16'd1229;
    localparam logic [15:0] RST_DZ_CUT   = 16'd3200;

    typedef logic signed [15:0] t_coord;
    typedef logic signed [16:0] t_delta;
    typedef logic [32:0]        t_dr2;

    typedef struct packed {
        t_coord eta;
        t_coord phi;
        t_coord z;
    } t_point;

    typedef struct packed {
        logic [2:0]  mode;
        logic [15:0] dr;
        logic [15:0] eta;
        logic [15:0] phi;
        logic [15:0] dz;
    } t_cut_cfg;

    // One evaluated track leaving the distance unit.
    typedef struct packed {
        logic        valid;
        logic [31:0] sq_eta;
        logic [31:0] sq_phi;
        t_delta      deta;
        t_delta      dphi;
        t_delta      dz;
    } t_dist_res;

    // Running nearest track and its cut decision.
    typedef struct packed {
        logic   found;
        logic   passed;
        t_dr2   d2;
        t_delta deta;
        t_delta dphi;
        t_delta dz;
    } t_best_res;

    // Magnitude of a difference of two 16-bit values; it always fits 16 bits.
    function automatic logic [15:0] delta_mag(t_delta d);
        logic [16:0] neg;
        neg = -d;
        return d[16] ? neg[15:0] : d[15:0];
    endfunction

endpackage

@@ sv/ntdrm_req_if.sv @@
interface ntdrm_req_if;
    logic               valid;
    logic               ready;
    logic [1:0]         opcode;
    logic signed [15:0] item_eta;
    logic signed [15:0] item_phi;
    logic signed [15:0] item_z;

    modport source (output valid, output opcode, output item_eta, output item_phi,
                    output item_z, input ready);
    modport sink   (input valid, input opcode, input item_eta, input item_phi,
                    input item_z, output ready);
endinterface

@@ sv/ntdrm_res_if.sv @@
interface ntdrm_res_if;
    logic               valid;
    logic               ready;
    logic               found;
    logic               passed;
    logic [7:0]         match_index;
    logic [32:0]        min_dr_squared;
    logic signed [16:0] delta_eta;
    logic signed [16:0] delta_phi;
    logic signed [16:0] delta_z;
    logic               list_overflowed;

    modport source (output valid, output found, output passed, output match_index,
                    output min_dr_squared, output delta_eta, output delta_phi,
                    output delta_z, output list_overflowed, input ready);
    modport sink   (input valid, input found, input passed, input match_index,
                    input min_dr_squared, input delta_eta, input delta_phi,
                    input delta_z, input list_overflowed, output ready);
endinterface

@@ sv/ntdrm_ram.sv @@
module ntdrm_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 256
) (
    input  logic                                     i_clk,
    input  logic                                     i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                         i_wdata,
    input  logic                                     i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ sv/ntdrm_dist.sv @@
module ntdrm_dist #(
    parameter int IDX_W = 8
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_issue,
    input  logic [IDX_W-1:0]     i_idx,
    input  ntdrm_pkg::t_point    i_query,
    input  ntdrm_pkg::t_point    i_track,
    output ntdrm_pkg::t_dist_res o_res,
    output logic [IDX_W-1:0]     o_idx,
    output logic                 o_busy
);
    import ntdrm_pkg::*;

    // Stage 0 lines up with the registered memory read.
    logic             r_v0;
    logic [IDX_W-1:0] r_idx0;
    // Stage 1: differences and magnitudes.
    logic             r_v1;
    logic [IDX_W-1:0] r_idx1;
    t_delta           r_deta1;
    t_delta           r_dphi1;
    t_delta           r_dz1;
    logic [15:0]      r_ae1;
    logic [15:0]      r_ap1;
    // Stage 2: squares.
    logic             r_v2;
    logic [IDX_W-1:0] r_idx2;
    t_delta           r_deta2;
    t_delta           r_dphi2;
    t_delta           r_dz2;
    logic [31:0]      r_sqe2;
    logic [31:0]      r_sqp2;

    t_delta de;
    t_delta dp;
    t_delta dzv;

    always_comb begin
        de  = {i_query.eta[15], i_query.eta} - {i_track.eta[15], i_track.eta};
        dp  = {i_query.phi[15], i_query.phi} - {i_track.phi[15], i_track.phi};
        dzv = {i_query.z[15], i_query.z} - {i_track.z[15], i_track.z};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            r_v0 <= i_issue;
            r_v1 <= r_v0;
            r_v2 <= r_v1;
        end
        r_idx0  <= i_idx;
        r_idx1  <= r_idx0;
        r_deta1 <= de;
        r_dphi1 <= dp;
        r_dz1   <= dzv;
        r_ae1   <= delta_mag(de);
        r_ap1   <= delta_mag(dp);
        r_idx2  <= r_idx1;
        r_deta2 <= r_deta1;
        r_dphi2 <= r_dphi1;
        r_dz2   <= r_dz1;
        r_sqe2  <= r_ae1 * r_ae1;
        r_sqp2  <= r_ap1 * r_ap1;
    end

    always_comb begin
        o_res.valid  = r_v2;
        o_res.sq_eta = r_sqe2;
        o_res.sq_phi = r_sqp2;
        o_res.deta   = r_deta2;
        o_res.dphi   = r_dphi2;
        o_res.dz     = r_dz2;
    end

    assign o_idx  = r_idx2;
    assign o_busy = r_v0 | r_v1 | r_v2;

endmodule

@@ sv/ntdrm_best.sv @@
module ntdrm_best #(
    parameter int IDX_W = 8
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  ntdrm_pkg::t_dist_res i_dist,
    input  logic [IDX_W-1:0]     i_dist_idx,
    input  ntdrm_pkg::t_cut_cfg  i_cfg,
    output ntdrm_pkg::t_best_res o_best,
    output logic [IDX_W-1:0]     o_idx
);
    import ntdrm_pkg::*;

    logic             r_found;
    t_dr2             r_d2;
    logic [IDX_W-1:0] r_idx;
    t_delta           r_deta;
    t_delta           r_dphi;
    t_delta           r_dz;
    logic [31:0]      r_dr_sq;

    t_dr2 d2;
    logic cut_ok;

    assign d2 = {1'b0, i_dist.sq_eta} + {1'b0, i_dist.sq_phi};

    always_ff @(posedge i_clk) begin
        // The user must change the limit only while idle, long before it is compared; the block does not enforce it.
        r_dr_sq <= i_cfg.dr * i_cfg.dr;
        if (!i_rst_n) begin
            r_found <= 1'b0;
        end else if (i_start) begin
            r_found <= 1'b0;
        end else if (i_dist.valid && (!r_found || d2 < r_d2)) begin
            // Strict compare keeps the earliest of equal distances.
            r_found <= 1'b1;
        end
        if (i_start) begin
            r_d2   <= '0;
            r_idx  <= '0;
            r_deta <= '0;
            r_dphi <= '0;
            r_dz   <= '0;
        end else if (i_dist.valid && (!r_found || d2 < r_d2)) begin
            r_d2   <= d2;
            r_idx  <= i_dist_idx;
            r_deta <= i_dist.deta;
            r_dphi <= i_dist.dphi;
            r_dz   <= i_dist.dz;
        end
    end

    always_comb begin
        unique case (i_cfg.mode)
            CUT_WINDOW: cut_ok = (delta_mag(r_deta) <= i_cfg.eta) &&
                                 (delta_mag(r_dphi) <= i_cfg.phi);
            CUT_DR:     cut_ok = r_d2 <= {1'b0, r_dr_sq};
            CUT_ETA:    cut_ok = delta_mag(r_deta) <= i_cfg.eta;
            CUT_PHI:    cut_ok = delta_mag(r_dphi) <= i_cfg.phi;
            CUT_DZ:     cut_ok = delta_mag(r_dz) <= i_cfg.dz;
            default:    cut_ok = 1'b1;
        endcase
    end

    always_comb begin
        o_best.found  = r_found;
        o_best.passed = r_found & cut_ok;
        o_best.d2     = r_d2;
        o_best.deta   = r_deta;
        o_best.dphi   = r_dphi;
        o_best.dz     = r_dz;
    end

    assign o_idx = r_idx;

endmodule

@@ sv/nearest_track_delta_r_matcher_top.sv @@
// Channel    Direction  Handshake        Carries
// i_req      in         valid / ready    opcode, item_eta, item_phi, item_z
// o_res      out        valid / ready    found, passed, match_index, min_dr_squared,
//                                        delta_eta, delta_phi, delta_z, list_overflowed
// apb        in / out   psel, penable    cut_mode, dr_cut, eta_cut, phi_cut, dz_cut
//
// After a clear or an append request the block is ready again at once.
// A query steps through the list over the one memory read port, one track per cycle.
// Reset is synchronous and active low; it empties the list and needs no clearing pass.
// A waiting result sits in the output register and does not stop requests; only a
// query that finishes while the previous result is still untaken waits for it.

module nearest_track_delta_r_matcher_top #(
    parameter int MAX_TRACKS = 256
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    ntdrm_req_if.sink                     i_req,
    ntdrm_res_if.source                   o_res,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [ntdrm_pkg::APB_AW-1:0]  paddr,
    input  logic [ntdrm_pkg::APB_DW-1:0]  pwdata,
    output logic [ntdrm_pkg::APB_DW-1:0]  prdata,
    output logic                          pready
);
    import ntdrm_pkg::*;

    // The count must hold MAX_TRACKS itself; the index only a position.
    localparam int CNT_W = $clog2(MAX_TRACKS + 1);
    localparam int IDX_W = (MAX_TRACKS > 1) ? $clog2(MAX_TRACKS) : 1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WALK,
        ST_DRAIN
    } t_state;

    // ------------------------------------------------------------------
    // Configuration registers. Writes complete in the access phase, and
    // since pready is tied high, no access has wait states.
    // ------------------------------------------------------------------
    t_cut_cfg   r_cfg;
    logic [2:0] reg_idx;
    logic       cfg_wr;

    assign pready  = 1'b1;
    assign reg_idx = paddr[APB_AW-1:2];
    assign cfg_wr  = psel & penable & pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.mode <= RST_CUT_MODE;
            r_cfg.dr   <= RST_DR_CUT;
            r_cfg.eta  <= RST_ETA_CUT;
            r_cfg.phi  <= RST_PHI_CUT;
            r_cfg.dz   <= RST_DZ_CUT;
        end else if (cfg_wr) begin
            unique case (reg_idx)
                REG_CUT_MODE: r_cfg.mode <= pwdata[2:0];
                REG_DR_CUT:   r_cfg.dr   <= pwdata[15:0];
                REG_ETA_CUT:  r_cfg.eta  <= pwdata[15:0];
                REG_PHI_CUT:  r_cfg.phi  <= pwdata[15:0];
                REG_DZ_CUT:   r_cfg.dz   <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_CUT_MODE: prdata = {29'b0, r_cfg.mode};
            REG_DR_CUT:   prdata = {16'b0, r_cfg.dr};
            REG_ETA_CUT:  prdata = {16'b0, r_cfg.eta};
            REG_PHI_CUT:  prdata = {16'b0, r_cfg.phi};
            REG_DZ_CUT:   prdata = {16'b0, r_cfg.dz};
            default:      prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Sequencer state, list bookkeeping and the output register.
    // ------------------------------------------------------------------
    t_state             r_state, n_state;
    logic [CNT_W-1:0]   r_count, n_count;
    logic               r_ovf, n_ovf;
    logic [IDX_W-1:0]   r_addr, n_addr;
    t_point             r_query, n_query;

    logic               r_out_valid, n_out_valid;
    logic               r_out_found, n_out_found;
    logic               r_out_passed, n_out_passed;
    logic [7:0]         r_out_idx, n_out_idx;
    t_dr2               r_out_d2, n_out_d2;
    t_delta             r_out_deta, n_out_deta;
    t_delta             r_out_dphi, n_out_dphi;
    t_delta             r_out_dz, n_out_dz;
    logic               r_out_ovf, n_out_ovf;

    logic               req_acc;
    logic               list_full;
    logic               walk_last;
    logic               start;
    logic               ram_we;
    logic               issue;
    t_point             req_point;
    t_point             track;
    logic [$bits(t_point)-1:0] ram_rdata;

    t_dist_res          dist_res;
    logic [IDX_W-1:0]   dist_idx;
    logic               dist_busy;
    t_best_res          best;
    logic [IDX_W-1:0]   best_idx;
    logic [IDX_W+7:0]   best_idx_wide;

    assign i_req.ready = (r_state == ST_IDLE);
    assign req_acc     = i_req.valid & i_req.ready;
    assign list_full   = (r_count == CNT_W'(MAX_TRACKS));
    // The walk ends once the address just issued is the last stored track.
    assign walk_last   = ((CNT_W'(r_addr) + CNT_W'(1)) == r_count);
    assign issue       = (r_state == ST_WALK);
    assign ram_we      = req_acc && (i_req.opcode == OP_APPEND) && !list_full;

    always_comb begin
        req_point.eta = i_req.item_eta;
        req_point.phi = i_req.item_phi;
        req_point.z   = i_req.item_z;
    end

    assign track         = t_point'(ram_rdata);
    assign best_idx_wide = {8'b0, best_idx};

    always_comb begin
        n_state      = r_state;
        n_count      = r_count;
        n_ovf        = r_ovf;
        n_addr       = r_addr;
        n_query      = r_query;
        start        = 1'b0;
        n_out_valid  = r_out_valid & ~o_res.ready;
        n_out_found  = r_out_found;
        n_out_passed = r_out_passed;
        n_out_idx    = r_out_idx;
        n_out_d2     = r_out_d2;
        n_out_deta   = r_out_deta;
        n_out_dphi   = r_out_dphi;
        n_out_dz     = r_out_dz;
        n_out_ovf    = r_out_ovf;

        unique case (r_state)
            ST_IDLE: begin
                if (req_acc) begin
                    unique case (i_req.opcode)
                        OP_CLEAR: begin
                            n_count = '0;
                            n_ovf   = 1'b0;
                        end
                        OP_APPEND: begin
                            if (list_full) begin
                                n_ovf = 1'b1;
                            end else begin
                                n_count = r_count + CNT_W'(1);
                            end
                        end
                        OP_QUERY: begin
                            n_query = req_point;
                            n_addr  = '0;
                            start   = 1'b1;
                            n_state = (r_count == '0) ? ST_DRAIN : ST_WALK;
                        end
                        default: ;
                    endcase
                end
            end
            ST_WALK: begin
                if (walk_last) begin
                    n_state = ST_DRAIN;
                end else begin
                    n_addr = r_addr + IDX_W'(1);
                end
            end
            ST_DRAIN: begin
                // Once the pipeline is empty the nearest track is final.
                if (!dist_busy && (!r_out_valid || o_res.ready)) begin
                    n_out_valid  = 1'b1;
                    n_out_found  = best.found;
                    n_out_passed = best.passed;
                    n_out_idx    = best_idx_wide[7:0];
                    n_out_d2     = best.d2;
                    n_out_deta   = best.deta;
                    n_out_dphi   = best.dphi;
                    n_out_dz     = best.dz;
                    n_out_ovf    = r_ovf;
                    n_state      = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= '0;
            r_ovf       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_ovf       <= n_ovf;
            r_out_valid <= n_out_valid;
        end
        r_addr       <= n_addr;
        r_query      <= n_query;
        r_out_found  <= n_out_found;
        r_out_passed <= n_out_passed;
        r_out_idx    <= n_out_idx;
        r_out_d2     <= n_out_d2;
        r_out_deta   <= n_out_deta;
        r_out_dphi   <= n_out_dphi;
        r_out_dz     <= n_out_dz;
        r_out_ovf    <= n_out_ovf;
    end

    assign o_res.valid           = r_out_valid;
    assign o_res.found           = r_out_found;
    assign o_res.passed          = r_out_passed;
    assign o_res.match_index     = r_out_idx;
    assign o_res.min_dr_squared  = r_out_d2;
    assign o_res.delta_eta       = r_out_deta;
    assign o_res.delta_phi       = r_out_dphi;
    assign o_res.delta_z         = r_out_dz;
    assign o_res.list_overflowed = r_out_ovf;

    // ------------------------------------------------------------------
    // Track store: eta, phi and z0 share one word so that one read per
    // cycle fetches a whole track.
    // ------------------------------------------------------------------
    ntdrm_ram #(
        .WIDTH ($bits(t_point)),
        .DEPTH (MAX_TRACKS)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_count[IDX_W-1:0]),
        .i_wdata (req_point),
        .i_re    (issue),
        .i_raddr (r_addr),
        .o_rdata (ram_rdata)
    );

    // Shared distance unit: differences, then squares, one track per cycle.
    ntdrm_dist #(
        .IDX_W (IDX_W)
    ) u_dist (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_issue (issue),
        .i_idx   (r_addr),
        .i_query (r_query),
        .i_track (track),
        .o_res   (dist_res),
        .o_idx   (dist_idx),
        .o_busy  (dist_busy)
    );

    // Running minimum and the selected cut on the winner.
    ntdrm_best #(
        .IDX_W (IDX_W)
    ) u_best (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (start),
        .i_dist     (dist_res),
        .i_dist_idx (dist_idx),
        .i_cfg      (r_cfg),
        .o_best     (best),
        .o_idx      (best_idx)
    );

endmodule

@@ sv/ntdrm_checker.sv @@
`include "nearest_track_delta_r_matcher_top_defines.svh"

module ntdrm_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_req_valid,
    input logic        i_req_ready,
    input logic [1:0]  i_req_opcode,
    input logic        i_res_valid,
    input logic        i_res_ready,
    input logic        i_res_found,
    input logic        i_res_passed,
    input logic [7:0]  i_res_match_index,
    input logic [32:0] i_res_min_dr_squared
);
    import ntdrm_pkg::*;

    // A result that is not taken stays offered.
    `NTDRM_ASSERT_NXT(a_res_hold, i_clk, i_rst_n, i_res_valid && !i_res_ready, i_res_valid, "result withdrawn before it was taken")

    // A query keeps the block busy for at least the following cycle.
    `NTDRM_ASSERT_NXT(a_query_busy, i_clk, i_rst_n, i_req_valid && i_req_ready && (i_req_opcode == OP_QUERY), !i_req_ready, "ready straight after a query")

    // After every other request the block is ready again in the following cycle.
    `NTDRM_ASSERT_NXT(a_short_ops, i_clk, i_rst_n, i_req_valid && i_req_ready && (i_req_opcode != OP_QUERY), i_req_ready, "not ready after a clear or append")

    // An empty list gives a fail and zeroed match fields.
    `NTDRM_ASSERT_IMP(a_empty_res, i_clk, i_rst_n, i_res_valid && !i_res_found, !i_res_passed && (i_res_match_index == 8'd0) && (i_res_min_dr_squared == 33'd0), "empty-list result not cleared")

endmodule

bind nearest_track_delta_r_matcher_top ntdrm_checker u_ntdrm_checker (
    .i_clk                (i_clk),
    .i_rst_n              (i_rst_n),
    .i_req_valid          (i_req.valid),
    .i_req_ready          (i_req.ready),
    .i_req_opcode         (i_req.opcode),
    .i_res_valid          (o_res.valid),
    .i_res_ready          (o_res.ready),
    .i_res_found          (o_res.found),
    .i_res_passed         (o_res.passed),
    .i_res_match_index    (o_res.match_index),
    .i_res_min_dr_squared (o_res.min_dr_squared)
);

@@ tb/nearest_track_delta_r_matcher_top_tb.sv @@
module nearest_track_delta_r_matcher_top_tb;
    import ntdrm_pkg::*;

    // Track list depth given to the block; the full-list phase fills it exactly.
    localparam int TRACK_CAP      = 256;
    localparam int CLK_PERIOD     = 10;
    // Long receiver hold-off used to back the block up until it refuses requests.
    localparam int HOLD_CYCLES    = 300;
    // Number of cut settings programmed after the directed part.
    localparam int CUT_PHASES     = 12;
    // Approximate number of random requests queued per cut setting.
    localparam int PHASE_BUDGET   = 17;
    localparam int PRESSURE_PHASE = 6;
    localparam int OVERFLOW_PHASE = 9;
    // Clears and appends leave the block ready at once and a query ends when its result
    // is out, so once the last result is seen the block is idle; the tail adds margin.
    localparam int SETTLE_TAIL    = 8;
    localparam int END_TAIL       = 20;
    // Cycles without any request taken or result seen before a drain gives up.
    localparam int STALL_LIMIT    = 2000;
    // The slowest legal run is about 600 requests, each at worst a full-list walk plus
    // sender gaps and receiver stalls; the watchdog allows several times what it needs.
    localparam int TIMEOUT_CYCLES = 1000000;
    // Register slots decoded by the five address bits; those above dz_cut are unused.
    localparam int REG_SLOTS      = 8;

    // The opcode left unused by the block; it must be taken and ignored.
    localparam logic [1:0] OP_SPARE = 2'd3;

    localparam t_coord COORD_MAX = 16'sh7FFF;
    localparam t_coord COORD_MIN = 16'sh8000;

    typedef struct packed {
        logic [1:0] op;
        t_coord     eta;
        t_coord     phi;
        t_coord     z;
    } track_request_t;

    typedef struct packed {
        logic       found;
        logic       passed;
        logic [7:0] index;
        t_dr2       d2;
        t_delta     deta;
        t_delta     dphi;
        t_delta     dz;
        logic       overflow;
    } match_result_t;

    logic              i_clk = 1'b0;
    logic              i_rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [APB_AW-1:0] paddr;
    logic [APB_DW-1:0] pwdata;
    logic [APB_DW-1:0] prdata;
    logic              pready;

    ntdrm_req_if req_bus ();
    ntdrm_res_if res_bus ();

    nearest_track_delta_r_matcher_top #(
        .MAX_TRACKS (TRACK_CAP)
    ) uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_bus),
        .o_res   (res_bus),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always begin
        #(CLK_PERIOD / 2) i_clk = 1'b1;
        #(CLK_PERIOD / 2) i_clk = 1'b0;
    end

    // Requests waiting for the driver, and the results owed by accepted queries.
    track_request_t pending_requests[$];
    match_result_t  expected_matches[$];

    int reqs_issued  = 0;
    int reqs_taken   = 0;
    int results_seen = 0;
    int mismatches   = 0;

    // Flow control knobs set by the stimulus process and read by the driver and the
    // receiver. The hold token asks the receiver for one long hold-off.
    logic sender_calm = 1'b0;
    int   hold_token  = 0;
    int   hold_seen   = 0;

    // Our own copy of the cut registers, updated whenever a write completes.
    logic [2:0]  cut_sel;
    logic [15:0] dr_limit;
    logic [15:0] eta_limit;
    logic [15:0] phi_limit;
    logic [15:0] dz_limit;

    // Our own copy of the track list. Entries at or above trk_count are never read.
    t_coord trk_eta [TRACK_CAP];
    t_coord trk_phi [TRACK_CAP];
    t_coord trk_z   [TRACK_CAP];
    int     trk_count = 0;
    logic   ovf_flag  = 1'b0;

    task automatic report_mismatch(input string what);
        $display("[%0t] mismatch: %s", $time, what);
        mismatches++;
    endtask

    task automatic check_field(input string name, input logic [63:0] got,
                               input logic [63:0] want);
        if (got !== want) begin
            report_mismatch($sformatf("%s got %0h, expected %0h", name, got, want));
        end
    endtask

    // Applies one accepted request to the track list and, for a query, works out the
    // nearest track and its cut decision.
    function automatic void predict_request(input logic [1:0] op, input t_coord eta,
                                            input t_coord phi, input t_coord z);
        match_result_t res;
        longint        d2;
        longint        best_d2;
        int            de;
        int            dp;
        int            dzv;
        int            best;
        logic          hit;
        logic          ok;
        res     = '0;
        best    = 0;
        best_d2 = 0;
        hit     = 1'b0;
        ok      = 1'b0;
        case (op)
            OP_CLEAR: begin
                trk_count = 0;
                ovf_flag  = 1'b0;
            end
            OP_APPEND: begin
                if (trk_count < TRACK_CAP) begin
                    trk_eta[trk_count] = eta;
                    trk_phi[trk_count] = phi;
                    trk_z[trk_count]   = z;
                    trk_count++;
                end else begin
                    ovf_flag = 1'b1;
                end
            end
            OP_QUERY: begin
                // Strictly smaller distance replaces the best, so the earliest of
                // several equal tracks is kept.
                for (int i = 0; i < trk_count; i++) begin
                    de = int'(eta) - int'(trk_eta[i]);
                    dp = int'(phi) - int'(trk_phi[i]);
                    d2 = longint'(de) * de + longint'(dp) * dp;
                    if (!hit || d2 < best_d2) begin
                        hit     = 1'b1;
                        best    = i;
                        best_d2 = d2;
                    end
                end
                if (hit) begin
                    de  = int'(eta) - int'(trk_eta[best]);
                    dp  = int'(phi) - int'(trk_phi[best]);
                    dzv = int'(z) - int'(trk_z[best]);
                    res.deta = de[16:0];
                    res.dphi = dp[16:0];
                    res.dz   = dzv[16:0];
                    if (de < 0) de = -de;
                    if (dp < 0) dp = -dp;
                    if (dzv < 0) dzv = -dzv;
                    case (cut_sel)
                        CUT_WINDOW: ok = (de <= eta_limit) && (dp <= phi_limit);
                        CUT_DR:     ok = best_d2 <= longint'(dr_limit) * longint'(dr_limit);
                        CUT_ETA:    ok = de <= eta_limit;
                        CUT_PHI:    ok = dp <= phi_limit;
                        CUT_DZ:     ok = dzv <= dz_limit;
                        default:    ok = 1'b1;
                    endcase
                end
                res.found    = hit;
                res.passed   = ok;
                res.index    = best[7:0];
                res.d2       = best_d2[32:0];
                res.overflow = ovf_flag;
                expected_matches.push_back(res);
            end
            default: begin
            end
        endcase
    endfunction

    // Sender: bursts of random length separated by random gaps. A request stays on
    // the bus until the block takes it; within a burst the next one is put on the bus in the same cycle.
    int burst_left = 1;
    int gap_left   = 0;

    always @(posedge i_clk) begin : drive_requests
        track_request_t nxt;
        if (!i_rst_n) begin
            req_bus.valid <= 1'b0;
        end else begin
            if (req_bus.valid && req_bus.ready) begin
                predict_request(req_bus.opcode, req_bus.item_eta, req_bus.item_phi,
                                req_bus.item_z);
                reqs_taken++;
                if (burst_left > 1) begin
                    burst_left--;
                end else begin
                    burst_left = $urandom_range(1, 24);
                    gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
                end
            end
            if (!req_bus.valid || req_bus.ready) begin
                if (gap_left > 0 && !sender_calm) begin
                    gap_left--;
                    req_bus.valid <= 1'b0;
                end else if (pending_requests.size() > 0) begin
                    gap_left = 0;
                    nxt = pending_requests.pop_front();
                    req_bus.valid    <= 1'b1;
                    req_bus.opcode   <= nxt.op;
                    req_bus.item_eta <= nxt.eta;
                    req_bus.item_phi <= nxt.phi;
                    req_bus.item_z   <= nxt.z;
                end else begin
                    req_bus.valid <= 1'b0;
                end
            end
        end
    end

    // Receiver: ready follows a 32-bit pattern that is drawn afresh each time it
    // runs out, sometimes solid, sometimes sparse. A hold token forces a long stall
    // that is counted down here.
    logic [31:0] stall_bits = '1;
    int          stall_pos  = 0;
    int          hold_left  = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            res_bus.ready <= 1'b0;
        end else begin
            if (hold_seen != hold_token) begin
                hold_seen = hold_token;
                hold_left = HOLD_CYCLES;
            end
            if (stall_pos == 0) begin
                case ($urandom_range(0, 3))
                    0:       stall_bits = '1;
                    1:       stall_bits = $urandom();
                    2:       stall_bits = $urandom() & $urandom();
                    default: stall_bits = $urandom() | $urandom();
                endcase
            end
            if (hold_left > 0) begin
                hold_left--;
                res_bus.ready <= 1'b0;
            end else begin
                res_bus.ready <= stall_bits[stall_pos];
            end
            stall_pos = (stall_pos + 1) % 32;
        end
    end

    // Result checker: every result taken is matched against the oldest query.
    always @(posedge i_clk) begin : check_results
        match_result_t want;
        if (i_rst_n && res_bus.valid && res_bus.ready) begin
            results_seen++;
            if (expected_matches.size() == 0) begin
                report_mismatch("result arrived with no query outstanding");
            end else begin
                want = expected_matches.pop_front();
                check_field("found", res_bus.found, want.found);
                check_field("passed", res_bus.passed, want.passed);
                check_field("match_index", res_bus.match_index, want.index);
                check_field("min_dr_squared", res_bus.min_dr_squared, want.d2);
                check_field("delta_eta", res_bus.delta_eta[16:0], want.deta[16:0]);
                check_field("delta_phi", res_bus.delta_phi[16:0], want.dphi[16:0]);
                check_field("delta_z", res_bus.delta_z[16:0], want.dz[16:0]);
                check_field("list_overflowed", res_bus.list_overflowed, want.overflow);
            end
        end
    end

    task automatic send_request(input logic [1:0] op, input t_coord eta, input t_coord phi,
                                input t_coord z);
        pending_requests.push_back(track_request_t'{op, eta, phi, z});
        reqs_issued++;
    endtask

    // Mostly random values, with the two ends of the range turning up often.
    function automatic t_coord any_coord();
        case ($urandom_range(0, 7))
            0:       return COORD_MIN;
            1:       return COORD_MAX;
            default: return t_coord'($urandom());
        endcase
    endfunction

    // A point near v, at a distance chosen to straddle the usual cut sizes.
    function automatic t_coord nudge(input t_coord v);
        int span;
        case ($urandom_range(0, 4))
            0:       span = 0;
            1:       span = 16;
            2:       span = 512;
            3:       span = 2048;
            default: span = 8192;
        endcase
        return t_coord'(int'(v) + int'($urandom_range(0, 2 * span)) - span);
    endfunction

    function automatic logic [15:0] pick_limit();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            2, 3, 4: return 16'($urandom_range(0, 4095));
            default: return 16'($urandom());
        endcase
    endfunction

    function automatic logic [31:0] shadow_value(input logic [2:0] idx);
        case (idx)
            REG_CUT_MODE: return 32'(cut_sel);
            REG_DR_CUT:   return 32'(dr_limit);
            REG_ETA_CUT:  return 32'(eta_limit);
            REG_PHI_CUT:  return 32'(phi_limit);
            REG_DZ_CUT:   return 32'(dz_limit);
            default:      return '0;
        endcase
    endfunction

    // APB write: setup cycle, then access until pready. Unused slots change nothing.
    task automatic write_register(input logic [2:0] idx, input logic [31:0] value);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_CUT_MODE: cut_sel   = value[2:0];
            REG_DR_CUT:   dr_limit  = value[15:0];
            REG_ETA_CUT:  eta_limit = value[15:0];
            REG_PHI_CUT:  phi_limit = value[15:0];
            REG_DZ_CUT:   dz_limit  = value[15:0];
            default: begin
            end
        endcase
    endtask

    // Reads every mapped register back and compares it with our copy.
    task automatic check_registers();
        logic [31:0] got;
        for (int r = 0; r <= int'(REG_DZ_CUT); r++) begin
            @(posedge i_clk);
            psel    <= 1'b1;
            penable <= 1'b0;
            pwrite  <= 1'b0;
            paddr   <= {3'(r), 2'b00};
            @(posedge i_clk);
            penable <= 1'b1;
            do @(posedge i_clk); while (!pready);
            got = prdata;
            psel    <= 1'b0;
            penable <= 1'b0;
            if (got !== shadow_value(3'(r))) begin
                report_mismatch($sformatf("register %0d reads %0h, expected %0h", r, got,
                                          shadow_value(3'(r))));
            end
        end
    endtask

    // Waits until every queued request has been taken and every query answered, giving
    // up if nothing moves for a long time, then lets the block settle.
    task automatic wait_until_settled(input int tail);
        int stuck;
        int last_taken;
        int last_seen;
        stuck      = 0;
        last_taken = reqs_taken;
        last_seen  = results_seen;
        while ((reqs_taken != reqs_issued || expected_matches.size() != 0)
               && stuck < STALL_LIMIT) begin
            @(posedge i_clk);
            if (reqs_taken != last_taken || results_seen != last_seen) begin
                stuck      = 0;
                last_taken = reqs_taken;
                last_seen  = results_seen;
            end else begin
                stuck++;
            end
        end
        repeat (tail) @(posedge i_clk);
    endtask

    // Well-formed sessions: usually a clear, a short list of tracks (now and then a
    // duplicate, to make ties), then queries aimed close to stored tracks so that the
    // cuts fall either way. A little noise with any opcode follows some sessions.
    task automatic queue_sessions(input int budget);
        t_coord pool_eta[$];
        t_coord pool_phi[$];
        t_coord pool_z[$];
        t_coord e;
        t_coord ph;
        t_coord zz;
        int     stop_at;
        int     pick;
        stop_at = reqs_issued + budget;
        while (reqs_issued < stop_at) begin
            if ($urandom_range(0, 3) != 0 || pool_eta.size() > 40) begin
                send_request(OP_CLEAR, any_coord(), any_coord(), any_coord());
                pool_eta.delete();
                pool_phi.delete();
                pool_z.delete();
            end
            repeat (($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 10)) begin
                if (pool_eta.size() > 0 && $urandom_range(0, 5) == 0) begin
                    pick = $urandom_range(0, pool_eta.size() - 1);
                    e    = pool_eta[pick];
                    ph   = pool_phi[pick];
                end else begin
                    e  = any_coord();
                    ph = any_coord();
                end
                zz = any_coord();
                send_request(OP_APPEND, e, ph, zz);
                pool_eta.push_back(e);
                pool_phi.push_back(ph);
                pool_z.push_back(zz);
            end
            repeat ($urandom_range(1, 5)) begin
                if (pool_eta.size() > 0 && $urandom_range(0, 3) != 0) begin
                    pick = $urandom_range(0, pool_eta.size() - 1);
                    send_request(OP_QUERY, nudge(pool_eta[pick]), nudge(pool_phi[pick]),
                                 nudge(pool_z[pick]));
                end else begin
                    send_request(OP_QUERY, any_coord(), any_coord(), any_coord());
                end
            end
            if ($urandom_range(0, 2) == 0) begin
                send_request(2'($urandom()), any_coord(), any_coord(), any_coord());
            end
        end
    endtask

    initial begin
        t_coord      head_eta;
        t_coord      head_phi;
        t_coord      tail_eta;
        t_coord      tail_phi;
        t_coord      e;
        t_coord      ph;
        logic [15:0] lim;

        // Every input is known from time zero.
        i_rst_n          = 1'b0;
        psel             = 1'b0;
        penable          = 1'b0;
        pwrite           = 1'b0;
        paddr            = '0;
        pwdata           = '0;
        req_bus.valid    = 1'b0;
        req_bus.opcode   = OP_CLEAR;
        req_bus.item_eta = '0;
        req_bus.item_phi = '0;
        req_bus.item_z   = '0;
        res_bus.ready    = 1'b0;
        cut_sel          = RST_CUT_MODE;
        dr_limit         = RST_DR_CUT;
        eta_limit        = RST_ETA_CUT;
        phi_limit        = RST_PHI_CUT;
        dz_limit         = RST_DZ_CUT;

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        check_registers();

        // Directed requests under the reset cuts (delta-R mode).
        // A query straight after reset meets an empty list.
        send_request(OP_QUERY, '0, '0, '0);
        // The spare opcode must be taken and leave the list alone.
        send_request(OP_SPARE, COORD_MAX, COORD_MAX, COORD_MAX);
        send_request(OP_APPEND, COORD_MAX, COORD_MAX, COORD_MAX);
        send_request(OP_APPEND, COORD_MIN, COORD_MIN, COORD_MIN);
        send_request(OP_APPEND, '0, '0, '0);
        send_request(OP_APPEND, '0, '0, '0);
        // Two equal tracks: the earlier one (position 2) must win.
        send_request(OP_QUERY, '0, '0, '0);
        // Exact hits on the corner tracks with the widest z differences.
        send_request(OP_QUERY, COORD_MAX, COORD_MAX, COORD_MIN);
        send_request(OP_QUERY, COORD_MIN, COORD_MIN, COORD_MAX);
        // Right on the delta-R limit, and one step beyond it.
        send_request(OP_QUERY, t_coord'(RST_DR_CUT), '0, '0);
        send_request(OP_QUERY, t_coord'(RST_DR_CUT + 16'd1), '0, '0);
        // After a clear the list is empty again.
        send_request(OP_CLEAR, COORD_MAX, COORD_MIN, COORD_MAX);
        send_request(OP_QUERY, COORD_MIN, COORD_MAX, '0);
        // Opposite corners give the largest possible squared distance.
        send_request(OP_APPEND, COORD_MIN, COORD_MAX, '0);
        send_request(OP_QUERY, COORD_MAX, COORD_MIN, '0);
        send_request(OP_SPARE, COORD_MIN, COORD_MIN, COORD_MIN);
        send_request(OP_QUERY, COORD_MAX, COORD_MIN, COORD_MAX);
        // The stimulus waits here until every directed result is in.
        wait_until_settled(SETTLE_TAIL);

        for (int p = 0; p < CUT_PHASES; p++) begin
            // The first eight settings walk through every cut mode; the first two
            // put all limits at zero and then at their maximum. Upper data bits are
            // random and must be dropped by the registers.
            write_register(REG_CUT_MODE, {29'($urandom()), 3'(p)});
            for (int r = int'(REG_DR_CUT); r <= int'(REG_DZ_CUT); r++) begin
                lim = (p == 0) ? 16'h0000 : (p == 1) ? 16'hFFFF : pick_limit();
                write_register(3'(r), {16'($urandom()), lim});
            end
            for (int r = int'(REG_DZ_CUT) + 1; r < REG_SLOTS; r++) begin
                write_register(3'(r), $urandom());
            end
            check_registers();

            if (p == PRESSURE_PHASE) begin
                // The receiver stalls for a long time while the sender offers back-to-
                // back queries: the output register fills, then the input stalls.
                send_request(OP_CLEAR, any_coord(), any_coord(), any_coord());
                repeat (4) send_request(OP_APPEND, any_coord(), any_coord(), any_coord());
                sender_calm = 1'b1;
                hold_token++;
                repeat (12) send_request(OP_QUERY, any_coord(), any_coord(), any_coord());
                wait_until_settled(SETTLE_TAIL);
                sender_calm = 1'b0;
            end

            if (p == OVERFLOW_PHASE) begin
                // Fill the list to capacity, push two more that must be dropped, and
                // query for the first and the last stored tracks with the flag set.
                send_request(OP_CLEAR, any_coord(), any_coord(), any_coord());
                head_eta = '0;
                head_phi = '0;
                tail_eta = '0;
                tail_phi = '0;
                for (int i = 0; i < TRACK_CAP + 2; i++) begin
                    e  = t_coord'($urandom());
                    ph = t_coord'($urandom());
                    if (i == 0) begin
                        head_eta = e;
                        head_phi = ph;
                    end
                    if (i == TRACK_CAP - 1) begin
                        tail_eta = e;
                        tail_phi = ph;
                    end
                    send_request(OP_APPEND, e, ph, any_coord());
                end
                send_request(OP_QUERY, head_eta, head_phi, any_coord());
                send_request(OP_QUERY, tail_eta, tail_phi, any_coord());
                send_request(OP_QUERY, any_coord(), any_coord(), any_coord());
                // A clear must also drop the overflow flag.
                send_request(OP_CLEAR, any_coord(), any_coord(), any_coord());
                send_request(OP_QUERY, any_coord(), any_coord(), any_coord());
                send_request(OP_APPEND, any_coord(), any_coord(), any_coord());
                send_request(OP_QUERY, any_coord(), any_coord(), any_coord());
            end

            queue_sessions(PHASE_BUDGET);
            wait_until_settled(SETTLE_TAIL);
        end

        wait_until_settled(END_TAIL);
        if (expected_matches.size() != 0 || reqs_taken != reqs_issued) begin
            report_mismatch($sformatf("%0d queries unanswered, %0d requests never taken",
                                      expected_matches.size(), reqs_issued - reqs_taken));
        end

        $display("Run covered %0d requests and %0d query results over %0d cut settings,",
                 reqs_taken, results_seen, CUT_PHASES + 1);
        $display("including ties, a full list with dropped appends and a long output stall.");
        if (mismatches == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

    // Watchdog: ends a run that hangs.
    initial begin
        #(longint'(TIMEOUT_CYCLES) * CLK_PERIOD);
        $display("Run stopped by the watchdog.");
        $display("TB_ERROR");
        $finish;
    end

endmodule
